### src/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  // table depth default and queue depth
  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned FifoDepth     = 2;

  // field widths
  localparam int unsigned CompW    = 32;
  localparam int unsigned JointW   = 8;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned EpsW     = 16;
  localparam int unsigned CapW     = 11;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_EPSILON  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 1'd1;

  // register reset values
  localparam logic [EpsW-1:0] EpsilonRst  = 16'd1;
  localparam logic [CapW-1:0] CapacityRst = 11'd1024;

  // item modes
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_MATCHED = 2'd0;
  localparam logic [StatusW-1:0] ST_ADDED   = 2'd1;
  localparam logic [StatusW-1:0] ST_DROPPED = 2'd2;
  localparam logic [StatusW-1:0] ST_STARTED = 2'd3;

  // one item; the front scales its normal to unit length
  typedef struct packed {
    logic              mode;
    logic [CompW-1:0]  pos_x;
    logic [CompW-1:0]  pos_y;
    logic [CompW-1:0]  pos_z;
    logic [CompW-1:0]  norm_x;
    logic [CompW-1:0]  norm_y;
    logic [CompW-1:0]  norm_z;
    logic [CompW-1:0]  tex_u;
    logic [CompW-1:0]  tex_v;
    logic [JointW-1:0] joint;
  } item_t;

endpackage

### src/vdi_fifo.sv
// ----------------------------------------------------------------------------
// vdi_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module vdi_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vdi_pkg::item_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output vdi_pkg::item_t item_o
);
  import vdi_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  item_t           mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### src/vdi_front.sv
// ----------------------------------------------------------------------------
// vdi_front
// Accepts items and normalizes the normal of vertex items: sum of squares on
// one shared multiplier, bitwise integer square root, then one restoring divider run per axis.
// ----------------------------------------------------------------------------
module vdi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  vdi_pkg::item_t item_i,
  output logic          push_o,
  output vdi_pkg::item_t item_o,
  input  logic          full_i
);
  import vdi_pkg::*;

  localparam int unsigned NumW = CompW + 16;
  localparam int unsigned QuoW = 17;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_SQR   = 3'd1;
  localparam logic [2:0] F_ROOT  = 3'd2;
  localparam logic [2:0] F_DLOAD = 3'd3;
  localparam logic [2:0] F_DIV   = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  logic [2:0]        state_q;
  item_t             item_q;
  logic [5:0]        cnt_q;
  logic [1:0]        sel_q;
  logic [63:0]       prod_q, acc_q, sv_q, rt_q, bit_q;
  logic [CompW-1:0]  len_q;
  logic [NumW-1:0]   num_q;
  logic [CompW-1:0]  rem_q;
  logic [QuoW-1:0]   quo_q;
  logic [CompW-1:0]  nrm_q [3];

  logic [CompW-1:0]  raw [3];
  logic [CompW-1:0]  mag [3];
  logic [63:0]       root_try;
  logic [CompW:0]    div_try;
  logic              div_bit;
  logic [QuoW-1:0]   quo_next;
  logic [CompW-1:0]  quo_ext;

  // raw normal and its magnitude per axis
  assign raw[0] = item_q.norm_x;
  assign raw[1] = item_q.norm_y;
  assign raw[2] = item_q.norm_z;
  for (genvar g = 0; g < 3; g++) begin : g_mag
    assign mag[g] = raw[g][CompW-1] ? (~raw[g] + 1'b1) : raw[g];
  end

  // one root step and one divide step
  assign root_try = rt_q + bit_q;
  assign div_try  = {rem_q, num_q[NumW-1]};
  assign div_bit  = (div_try >= {1'b0, len_q});
  assign quo_next = {quo_q[QuoW-2:0], div_bit};
  assign quo_ext  = CompW'(quo_next);

  assign busy_o = (state_q != F_IDLE);
  assign push_o = (state_q == F_PUSH) && !full_i;

  // classified item toward the queue
  always_comb begin
    item_o        = item_q;
    item_o.norm_x = nrm_q[0];
    item_o.norm_y = nrm_q[1];
    item_o.norm_z = nrm_q[2];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= (item_i.mode == MODE_START) ? F_PUSH : F_SQR;
            cnt_q   <= '0;
          end
        end
        F_SQR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd3) begin
            state_q <= F_ROOT;
          end
        end
        F_ROOT: begin
          if (bit_q == '0) begin
            sel_q   <= '0;
            state_q <= (rt_q == '0) ? F_PUSH : F_DLOAD;
          end
        end
        F_DLOAD: begin
          cnt_q   <= '0;
          state_q <= F_DIV;
        end
        F_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'(NumW - 1)) begin
            sel_q   <= sel_q + 1'b1;
            state_q <= (sel_q == 2'd2) ? F_PUSH : F_DLOAD;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          item_q <= item_i;
          acc_q  <= '0;
        end
      end
      F_SQR: begin
        if (cnt_q < 6'd3) begin
          prod_q <= mag[cnt_q[1:0]] * mag[cnt_q[1:0]];
        end
        if (cnt_q != 6'd0) begin
          acc_q <= acc_q + prod_q;
        end
        if (cnt_q == 6'd3) begin
          sv_q  <= acc_q + prod_q;
          rt_q  <= '0;
          bit_q <= 64'd1 << 62;
        end
      end
      F_ROOT: begin
        if (bit_q != '0) begin
          if (sv_q >= root_try) begin
            sv_q <= sv_q - root_try;
            rt_q <= (rt_q >> 1) + bit_q;
          end else begin
            rt_q <= rt_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q <= rt_q[CompW-1:0];
          // zero normal stays zero
          for (int k = 0; k < 3; k++) begin
            nrm_q[k] <= '0;
          end
        end
      end
      F_DLOAD: begin
        num_q <= {mag[sel_q], 16'd0} + NumW'(len_q >> 1);
        rem_q <= '0;
        quo_q <= '0;
      end
      F_DIV: begin
        rem_q <= div_bit ? CompW'(div_try - {1'b0, len_q}) : div_try[CompW-1:0];
        num_q <= {num_q[NumW-2:0], 1'b0};
        quo_q <= quo_next;
        if (cnt_q == 6'(NumW - 1)) begin
          nrm_q[sel_q] <= raw[sel_q][CompW-1] ? (~quo_ext + 1'b1) : quo_ext;
        end
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### src/vdi_back.sv
// ----------------------------------------------------------------------------
// vdi_back
// Searches the vertex table in order, one entry a cycle, then matches,
// appends or drops, and emits one result per item.
// ----------------------------------------------------------------------------
module vdi_back #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  vdi_pkg::item_t               item_i,
  output logic                         pop_o,
  input  logic [vdi_pkg::EpsW-1:0]     epsilon_i,
  input  logic [vdi_pkg::CapW-1:0]     capacity_i,
  output logic                         result_valid_o,
  output logic [vdi_pkg::IndexW-1:0]   vertex_index_o,
  output logic [vdi_pkg::StatusW-1:0]  status_o
);
  import vdi_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;

  localparam logic [0:0] B_IDLE   = 1'b0;
  localparam logic [0:0] B_SEARCH = 1'b1;

  logic [0:0]          state_q;
  item_t               cur_q;
  item_t               rd_q;
  item_t               mem_q [TABLE_DEPTH];
  logic [CW-1:0]       vcnt_q, icnt_q, ra_q;
  logic [IW-1:0]       cidx_q;
  logic                pend_q;
  logic                valid_q;
  logic [IW-1:0]       idx_q;
  logic [StatusW-1:0]  status_q;

  logic [LW-1:0]       cap_ext, dep_ext, limit, vcnt_ext, icnt_ext;
  logic                issue, hit, vroom, iroom, append;
  logic [IW+IndexW-1:0] idx_ext;

  function automatic logic near(input logic [CompW-1:0] a, input logic [CompW-1:0] b,
                                input logic [EpsW-1:0] eps);
    logic [CompW:0] d;
    logic [CompW:0] ad;
    d    = {a[CompW-1], a} - {b[CompW-1], b};
    ad   = d[CompW] ? (~d + 1'b1) : d;
    near = (ad < (CompW+1)'(eps));
  endfunction

  // effective limit and room checks
  assign cap_ext  = LW'(capacity_i);
  assign dep_ext  = LW'(TABLE_DEPTH);
  assign limit    = (cap_ext < dep_ext) ? cap_ext : dep_ext;
  assign vcnt_ext = LW'(vcnt_q);
  assign icnt_ext = LW'(icnt_q);
  assign vroom    = (vcnt_ext < limit);
  assign iroom    = (icnt_ext < limit);

  // compare of the entry read last cycle
  assign hit = near(rd_q.pos_x, cur_q.pos_x, epsilon_i) &&
               near(rd_q.pos_y, cur_q.pos_y, epsilon_i) &&
               near(rd_q.pos_z, cur_q.pos_z, epsilon_i) &&
               near(rd_q.norm_x, cur_q.norm_x, epsilon_i) &&
               near(rd_q.norm_y, cur_q.norm_y, epsilon_i) &&
               near(rd_q.norm_z, cur_q.norm_z, epsilon_i) &&
               near(rd_q.tex_u, cur_q.tex_u, epsilon_i) &&
               near(rd_q.tex_v, cur_q.tex_v, epsilon_i) &&
               (rd_q.joint == cur_q.joint);

  assign issue  = (ra_q < vcnt_q);
  assign pop_o  = (state_q == B_IDLE) && !empty_i;
  assign append = (state_q == B_SEARCH) && !(pend_q && hit) && !issue && vroom && iroom;

  // control and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      vcnt_q  <= '0;
      icnt_q  <= '0;
      ra_q    <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            if (item_i.mode == MODE_START) begin
              vcnt_q  <= '0;
              icnt_q  <= '0;
              valid_q <= 1'b1;
            end else begin
              ra_q    <= '0;
              pend_q  <= 1'b0;
              state_q <= B_SEARCH;
            end
          end
        end
        B_SEARCH: begin
          priority if (pend_q && hit) begin
            if (iroom) begin
              icnt_q <= icnt_q + 1'b1;
            end
            valid_q <= 1'b1;
            state_q <= B_IDLE;
          end else if (!issue) begin
            if (append) begin
              vcnt_q <= vcnt_q + 1'b1;
              icnt_q <= icnt_q + 1'b1;
            end
            valid_q <= 1'b1;
            state_q <= B_IDLE;
          end else begin
            ra_q   <= ra_q + 1'b1;
            pend_q <= 1'b1;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // item hold, result payload, search index
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          cur_q    <= item_i;
          idx_q    <= '0;
          status_q <= ST_STARTED;
        end
      end
      B_SEARCH: begin
        priority if (pend_q && hit) begin
          idx_q    <= iroom ? cidx_q : '0;
          status_q <= iroom ? ST_MATCHED : ST_DROPPED;
        end else if (!issue) begin
          idx_q    <= append ? vcnt_q[IW-1:0] : '0;
          status_q <= append ? ST_ADDED : ST_DROPPED;
        end else begin
          cidx_q <= ra_q[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // vertex table
  always_ff @(posedge clk_i) begin
    if (append) begin
      mem_q[vcnt_q[IW-1:0]] <= cur_q;
    end
    if (state_q == B_SEARCH && issue) begin
      rd_q <= mem_q[ra_q[IW-1:0]];
    end
  end

  assign idx_ext        = (IW + IndexW)'(idx_q);
  assign result_valid_o = valid_q;
  assign vertex_index_o = idx_ext[IndexW-1:0];
  assign status_o       = status_q;

endmodule

### src/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Builds an indexed mesh by welding vertices that match within a tolerance.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start_i is high and busy_o is low. mode_i low
// starts a new mesh (counts cleared, status started); mode_i high adds one
// vertex. Each item yields exactly one result on vertex_index_o / status_o,
// marked by result_valid_o for one cycle; the receiver cannot stall.
// Configuration: a write transaction on cfg_valid_i / cfg_ready_o carries
// cfg_index_i (0 epsilon, 1 capacity) and cfg_data_i; ready is always high.
// Write it only while the block is idle.
// A start item passes the front's push state and the queue, and the back
// gives its result when it pops it. A vertex item passes through the front
// (sum of squares, square root, then the divider once per axis), then the
// back reads the table one entry a cycle until a match or the end.
// The front takes the next item while the back is still searching, with a
// two-entry queue between them.
// Reset: counts cleared, epsilon 1, capacity 1024; table contents undefined.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer #(
  parameter int unsigned TABLE_DEPTH = vdi_pkg::TableDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              mode_i,
  input  logic signed [vdi_pkg::CompW-1:0]  pos_x_i,
  input  logic signed [vdi_pkg::CompW-1:0]  pos_y_i,
  input  logic signed [vdi_pkg::CompW-1:0]  pos_z_i,
  input  logic signed [vdi_pkg::CompW-1:0]  norm_x_i,
  input  logic signed [vdi_pkg::CompW-1:0]  norm_y_i,
  input  logic signed [vdi_pkg::CompW-1:0]  norm_z_i,
  input  logic signed [vdi_pkg::CompW-1:0]  tex_u_i,
  input  logic signed [vdi_pkg::CompW-1:0]  tex_v_i,
  input  logic        [vdi_pkg::JointW-1:0] joint_i,
  output logic                              result_valid_o,
  output logic        [vdi_pkg::IndexW-1:0] vertex_index_o,
  output logic        [vdi_pkg::StatusW-1:0] status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic        [vdi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [vdi_pkg::CfgDataW-1:0] cfg_data_i
);
  import vdi_pkg::*;

  item_t            in_item, front_item, fifo_item;
  logic             push, full, pop, empty;
  logic [EpsW-1:0]  eps_q;
  logic [CapW-1:0]  cap_q;

  // input fields into one item
  always_comb begin
    in_item.mode   = mode_i;
    in_item.pos_x  = pos_x_i;
    in_item.pos_y  = pos_y_i;
    in_item.pos_z  = pos_z_i;
    in_item.norm_x = norm_x_i;
    in_item.norm_y = norm_y_i;
    in_item.norm_z = norm_z_i;
    in_item.tex_u  = tex_u_i;
    in_item.tex_v  = tex_v_i;
    in_item.joint  = joint_i;
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsilonRst;
      cap_q <= CapacityRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_EPSILON:  eps_q <= cfg_data_i[EpsW-1:0];
        REG_CAPACITY: cap_q <= cfg_data_i[CapW-1:0];
        default: begin
        end
      endcase
    end
  end

  vdi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .item_i (in_item),
    .push_o (push),
    .item_o (front_item),
    .full_i (full)
  );

  vdi_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (fifo_item)
  );

  vdi_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (fifo_item),
    .pop_o         (pop),
    .epsilon_i     (eps_q),
    .capacity_i    (cap_q),
    .result_valid_o(result_valid_o),
    .vertex_index_o(vertex_index_o),
    .status_o      (status_o)
  );

endmodule

### src/vdi_checker.sv
// ----------------------------------------------------------------------------
// vdi_checker
// Port-level checks of the vertex dedup indexer, bound to the top level.
// ----------------------------------------------------------------------------
module vdi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           result_valid_o,
  input logic [vdi_pkg::IndexW-1:0]     vertex_index_o,
  input logic [vdi_pkg::StatusW-1:0]    status_o
);
  import vdi_pkg::*;

  // an accepted item keeps the front busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted item did not raise busy");

  // a result always carries a known payload
  a_known_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown({vertex_index_o, status_o}))
    else $error("result with unknown payload");

  // start results carry index zero
  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_STARTED |-> vertex_index_o == '0)
    else $error("start result with non-zero index");

  // dropped results carry index zero
  a_drop_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_DROPPED |-> vertex_index_o == '0)
    else $error("dropped result with non-zero index");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the vertex dedup indexer: a directed table, then
// random meshes of welded, near and fresh vertices, checked by a local model.
// ----------------------------------------------------------------------------
module testbench;
  import vdi_pkg::*;

  localparam int unsigned Depth     = 1024;
  localparam int unsigned StallMax  = 20000;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseLen  = 86;

  typedef struct packed {
    logic [IndexW-1:0]  idx;
    logic [StatusW-1:0] st;
  } mesh_result_t;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    item_t               it;
    bit                  typed;
    mesh_result_t        want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                mode_i;
  logic [CompW-1:0]    pos_x_i, pos_y_i, pos_z_i;
  logic [CompW-1:0]    norm_x_i, norm_y_i, norm_z_i;
  logic [CompW-1:0]    tex_u_i, tex_v_i;
  logic [JointW-1:0]   joint_i;
  logic                result_valid_o;
  logic [IndexW-1:0]   vertex_index_o;
  logic [StatusW-1:0]  status_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // model state
  item_t        weld_tbl[Depth];
  int unsigned  vert_cnt, idx_cnt;
  logic [EpsW-1:0] eps_reg;
  logic [CapW-1:0] cap_reg;

  mesh_result_t pending_results[$];
  item_t        vtx_pool[$];
  dir_row_t     dir_rows[$];
  int unsigned  error_count;
  int unsigned  stall_cycles;
  int unsigned  idle_pct;

  vertex_dedup_indexer #(.TABLE_DEPTH(Depth)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .norm_x_i, .norm_y_i, .norm_z_i,
    .tex_u_i, .tex_v_i, .joint_i,
    .result_valid_o, .vertex_index_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // bitwise integer square root of a 64-bit sum
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one unit-normal component, rounded half away from zero
  function automatic logic [CompW-1:0] unit_comp(logic signed [63:0] n, logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    if (len == 0) return '0;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = ((mag << 16) + (len >> 1)) / len;
    return (n < 0) ? 32'(0 - q[31:0]) : q[31:0];
  endfunction

  function automatic bit close(logic [CompW-1:0] a, logic [CompW-1:0] b);
    logic signed [63:0] sa, sb, d;
    sa = $signed(a);
    sb = $signed(b);
    d = sa - sb;
    if (d < 0) d = -d;
    return 64'(d) < {48'd0, eps_reg};
  endfunction

  // weld one item into the local mesh and give its result
  function automatic mesh_result_t weld(item_t it);
    logic signed [63:0] sx, sy, sz;
    logic [63:0] len;
    item_t nv;
    int unsigned lim, i;
    mesh_result_t r;
    r = '{idx: '0, st: ST_DROPPED};
    if (it.mode == MODE_START) begin
      vert_cnt = 0;
      idx_cnt = 0;
      r.st = ST_STARTED;
      return r;
    end
    sx = $signed(it.norm_x);
    sy = $signed(it.norm_y);
    sz = $signed(it.norm_z);
    len = root64(64'(sx * sx) + 64'(sy * sy) + 64'(sz * sz));
    nv = it;
    nv.norm_x = unit_comp(sx, len);
    nv.norm_y = unit_comp(sy, len);
    nv.norm_z = unit_comp(sz, len);
    lim = (cap_reg < Depth) ? cap_reg : Depth;
    for (i = 0; i < vert_cnt; i++) begin
      if (close(weld_tbl[i].pos_x, nv.pos_x) && close(weld_tbl[i].pos_y, nv.pos_y) &&
          close(weld_tbl[i].pos_z, nv.pos_z) && close(weld_tbl[i].norm_x, nv.norm_x) &&
          close(weld_tbl[i].norm_y, nv.norm_y) && close(weld_tbl[i].norm_z, nv.norm_z) &&
          close(weld_tbl[i].tex_u, nv.tex_u) && close(weld_tbl[i].tex_v, nv.tex_v) &&
          weld_tbl[i].joint == nv.joint)
        break;
    end
    if (i < vert_cnt) begin
      if (idx_cnt < lim) begin
        idx_cnt++;
        r = '{idx: IndexW'(i), st: ST_MATCHED};
      end
    end else if (vert_cnt < lim && idx_cnt < lim) begin
      weld_tbl[vert_cnt] = nv;
      r = '{idx: IndexW'(vert_cnt), st: ST_ADDED};
      vert_cnt++;
      idx_cnt++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // result checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result: index %0d status %0d", vertex_index_o, status_o);
          error_count++;
        end else begin
          mesh_result_t w;
          w = pending_results.pop_front();
          if (vertex_index_o !== w.idx) report_mismatch("vertex_index", vertex_index_o, w.idx);
          if (status_o !== w.st) report_mismatch("status", status_o, w.st);
        end
      end
      if (result_valid_o || (start_i && !busy_o)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallMax) begin
        $display("vertex_dedup_indexer test failed");
        $finish;
      end
    end
  end

  // drive one item and wait for its transaction
  task automatic send_item(item_t it, bit typed, mesh_result_t want);
    mesh_result_t p;
    start_i  <= 1'b1;
    mode_i   <= it.mode;
    pos_x_i  <= it.pos_x;
    pos_y_i  <= it.pos_y;
    pos_z_i  <= it.pos_z;
    norm_x_i <= it.norm_x;
    norm_y_i <= it.norm_y;
    norm_z_i <= it.norm_z;
    tex_u_i  <= it.tex_u;
    tex_v_i  <= it.tex_v;
    joint_i  <= it.joint;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = weld(it);
    pending_results.push_back(typed ? want : p);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // hold off until every result is back, then let the block settle
  task automatic drain();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_EPSILON) eps_reg = data[EpsW-1:0];
    else cap_reg = data[CapW-1:0];
  endtask

  function automatic item_t vtx(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                logic [31:0] tu, logic [31:0] tv, logic [7:0] j);
    return '{mode: MODE_VERTEX, pos_x: px, pos_y: py, pos_z: pz, norm_x: nx,
             norm_y: ny, norm_z: nz, tex_u: tu, tex_v: tv, joint: j};
  endfunction

  function automatic void row_item(item_t it, bit typed, int unsigned idx, logic [1:0] st);
    dir_row_t r;
    r.is_cfg = 1'b0; r.reg_idx = '0; r.reg_data = '0;
    r.it = it; r.typed = typed; r.want = '{idx: IndexW'(idx), st: st};
    dir_rows.push_back(r);
  endfunction

  function automatic void row_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    dir_row_t r;
    r.is_cfg = 1'b1; r.reg_idx = idx; r.reg_data = data;
    r.it = '0; r.typed = 1'b0; r.want = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      2: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] v);
    int d;
    d = $urandom_range(0, eps_reg);
    return ($urandom_range(1)) ? v + 32'(d) : v - 32'(d);
  endfunction

  // random item: mostly near copies of vertices already in this mesh
  function automatic item_t next_item();
    item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) begin
      it = '0;
      it.mode = MODE_START;
      it.pos_x = $urandom;
      it.joint = 8'($urandom);
      vtx_pool.delete();
      return it;
    end
    if (pick < 40 || vtx_pool.size() == 0) begin
      it = vtx(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), rand_comp(), rand_comp(), 8'($urandom));
      if ($urandom_range(3) == 0) it.joint = 8'($urandom_range(0, 3));
      vtx_pool.push_back(it);
      return it;
    end
    it = vtx_pool[$urandom_range(0, vtx_pool.size() - 1)];
    if ($urandom_range(1)) it.pos_x = nudge(it.pos_x);
    if ($urandom_range(1)) it.pos_y = nudge(it.pos_y);
    if ($urandom_range(1)) it.pos_z = nudge(it.pos_z);
    if ($urandom_range(1)) it.tex_u = nudge(it.tex_u);
    if ($urandom_range(1)) it.tex_v = nudge(it.tex_v);
    // broken copies: other joint or another normal
    if (pick >= 88) begin
      if ($urandom_range(1)) it.joint = it.joint + 8'($urandom_range(1, 255));
      else it.norm_y = rand_comp();
    end
    return it;
  endfunction

  // stimulus
  initial begin
    logic [15:0] eps_set[NumPhases];
    logic [15:0] cap_set[NumPhases];
    item_t st_it;
    item_t a;
    eps_set = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd7, 16'd40};
    cap_set = '{16'd1024, 16'd1, 16'd0, 16'd37, 16'd12, 16'd1024};
    error_count = 0;
    stall_cycles = 0;
    idle_pct = 31;
    vert_cnt = 0;
    idx_cnt = 0;
    eps_reg = EpsilonRst;
    cap_reg = CapacityRst;
    rst_ni = 1'b0;
    start_i = 1'b0; mode_i = 1'b0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    norm_x_i = '0; norm_y_i = '0; norm_z_i = '0;
    tex_u_i = '0; tex_v_i = '0; joint_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    st_it = '0;
    st_it.mode = MODE_START;
    a = vtx(32'h0001_0000, 32'h0002_0000, 32'hffff_0000, 32'h0, 32'h0001_0000, 32'h0,
            32'h0000_8000, 32'h0000_4000, 8'd5);
    row_item(st_it, 1, 0, ST_STARTED);
    row_item(vtx(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, ST_ADDED);
    row_item(vtx(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, ST_MATCHED);
    row_item(vtx(0, 0, 0, 0, 0, 0, 0, 0, 8'hff), 1, 1, ST_ADDED);
    row_item(vtx('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, 0, 0, '1 >> 1, '1 >> 1, 8'h80),
             1, 2, ST_ADDED);
    // normal of three most negative values, the largest sum of squares
    row_item(vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h7f),
             0, 0, ST_ADDED);
    row_item(vtx(1, 2, 3, 3, 32'hffff_fffc, 0, 4, 5, 1), 0, 0, ST_ADDED);
    row_item(vtx(1, 2, 3, 1, 1, 2, 4, 5, 1), 0, 0, ST_ADDED);
    row_item(vtx(32'h1234_5678, 32'hedcb_a987, 7, 0, 0, 0, 9, 9, 2), 0, 0, ST_ADDED);
    // zero tolerance: nothing welds
    row_cfg(REG_EPSILON, 16'd0);
    row_item(vtx(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, ST_ADDED);
    // one-entry mesh fills up at once
    row_cfg(REG_CAPACITY, 16'd1);
    row_item(st_it, 1, 0, ST_STARTED);
    row_item(a, 1, 0, ST_ADDED);
    row_item(a, 1, 0, ST_DROPPED);
    row_cfg(REG_EPSILON, 16'd1);
    row_item(a, 1, 0, ST_DROPPED);
    // no room at all
    row_cfg(REG_CAPACITY, 16'd0);
    row_item(st_it, 1, 0, ST_STARTED);
    row_item(a, 1, 0, ST_DROPPED);
    // widest tolerance, edge of the window
    row_cfg(REG_CAPACITY, 16'd1024);
    row_cfg(REG_EPSILON, 16'd65535);
    row_item(st_it, 1, 0, ST_STARTED);
    row_item(a, 1, 0, ST_ADDED);
    row_item(vtx(32'h0001_fffe, 32'h0002_0000, 32'hffff_0000, 0, 32'h0001_0000, 0,
                 32'h0000_8000, 32'h0000_4000, 8'd5), 1, 0, ST_MATCHED);
    row_item(vtx(32'h0001_ffff, 32'h0002_0000, 32'hffff_0000, 0, 32'h0001_0000, 0,
                 32'h0000_8000, 32'h0000_4000, 8'd5), 1, 1, ST_ADDED);
    // capacity lowered mid-mesh: stored vertex still found, index refused
    row_cfg(REG_CAPACITY, 16'd1);
    row_item(a, 1, 0, ST_DROPPED);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_data);
      else send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
    end

    // random phases
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_pct = (ph < 2) ? 31 : (ph < 4) ? 72 : 0;
      write_reg(REG_EPSILON, eps_set[ph]);
      write_reg(REG_CAPACITY, cap_set[ph]);
      vtx_pool.delete();
      send_item(st_it, 0, '0);
      for (int n = 0; n < PhaseLen; n++) begin
        send_item(next_item(), 0, '0);
        if ($urandom_range(49) == 0) drain();
        else maybe_idle();
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("vertex_dedup_indexer test passed");
    end else begin
      $display("vertex_dedup_indexer test failed");
    end
    $finish;
  end

endmodule

### files.f
src/vdi_pkg.sv
src/vdi_fifo.sv
src/vdi_front.sv
src/vdi_back.sv
src/vertex_dedup_indexer.sv
src/vdi_checker.sv
tb/sv/testbench.sv
